FILE: sv/acs_pkg.sv
// Shared widths, codes and defaults of the absorbance calibration sequencer.
package acs_pkg;

   localparam int MODE_W      = 2;
   localparam int ADC_W       = 12;
   localparam int SUM_W       = 18;
   localparam int TICK_W      = 6;
   localparam int ROUND_W     = 8;
   localparam int MEAN_W      = 16;
   localparam int TOTAL_W     = 22;
   localparam int STD_W       = 20;
   localparam int WARM_W      = 8;
   localparam int SETTLE_W    = 4;
   localparam int LOG_W       = 20;
   localparam int RAW_W       = 20;
   localparam int ACC_W       = 49;
   localparam int PROD_W      = 40;
   localparam int DEN_W       = 20;
   localparam int ABS_W       = 24;
   localparam int FLAG_W      = 3;
   localparam int ADDR_W      = 4;
   localparam int DATA_W      = 32;

   localparam int TICKS_PER_ROUND_DEF = 50;
   localparam int AVERAGE_ROUNDS_DEF  = 10;
   localparam int SAMPLE_BITS_DEF     = 12;

   localparam logic [28:0]       LOG10_2_Q30   = 29'd323228497;
   localparam logic [STD_W-1:0]  STD_ABS_RST   = 20'd6554;
   localparam logic [WARM_W-1:0] WARMUP_RST    = 8'd25;
   localparam logic [SETTLE_W-1:0] SETTLE_RST  = 4'd3;

   typedef enum logic [2:0] {
      ST_WARMUP    = 3'd0,
      ST_AW_BLANK  = 3'd1,
      ST_AW_STD    = 3'd2,
      ST_AW_SAMPLE = 3'd3,
      ST_MEASURING = 3'd4
   } ctrl_code_type;

   typedef enum logic [2:0] {
      PH_NONE   = 3'd0,
      PH_WARMUP = 3'd1,
      PH_BLANK  = 3'd2,
      PH_STD    = 3'd3,
      PH_SAMPLE = 3'd4
   } phase_code_type;

   typedef enum logic [1:0] {
      SP_NONE    = 2'd0,
      SP_WARMUP  = 2'd1,
      SP_SETTLE  = 2'd2,
      SP_AVERAGE = 2'd3
   } sub_code_type;

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_RESTART = 2'd1,
      MODE_START   = 2'd2,
      MODE_RESET   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_STD_ABS = 2'd0,
      REG_WARMUP  = 2'd1,
      REG_SETTLE  = 2'd2
   } reg_index_type;

endpackage

FILE: sv/acs_if.sv
// Request and response channel interfaces of the sequencer.
interface acs_req_if import acs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [ADC_W-1:0]  adc_value;
   modport source (output valid, mode, adc_value, input ready);
   modport sink   (input valid, mode, adc_value, output ready);
endinterface

interface acs_rsp_if import acs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [2:0]              state_code;
   logic [2:0]              phase_code;
   logic [1:0]              subphase_code;
   logic [ROUND_W-1:0]      round_number;
   logic                    round_done;
   logic [MEAN_W-1:0]       round_mean_q4;
   logic                    final_done;
   logic [MEAN_W-1:0]       final_mean_q4;
   logic signed [ABS_W-1:0] absorbance_q16;
   logic [FLAG_W-1:0]       calib_flags;
   modport source (output valid, state_code, phase_code, subphase_code, round_number,
                   round_done, round_mean_q4, final_done, final_mean_q4,
                   absorbance_q16, calib_flags, input ready);
   modport sink   (input valid, state_code, phase_code, subphase_code, round_number,
                   round_done, round_mean_q4, final_done, final_mean_q4,
                   absorbance_q16, calib_flags, output ready);
endinterface

FILE: sv/acs_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module acs_div import acs_pkg::*; #(
   parameter int NUM_W = PROD_W,
   parameter int DIV_W = DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] q_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] den_ff;
   logic [DIV_W:0]   trial;
   logic             ge;
   logic [DIV_W:0]   diff;

   assign trial = {rem_ff, q_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
            q_ff    <= num;
            rem_ff  <= '0;
            den_ff  <= den;
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            q_ff   <= {q_ff[NUM_W-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

FILE: sv/acs_log10.sv
// Fixed-point log10 ratio: two squaring log2 passes and a bit-serial scale.
module acs_log10 import acs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [MEAN_W-1:0]       num,
   input  logic [MEAN_W-1:0]       den,
   output logic                    done,
   output logic signed [RAW_W-1:0] ratio
);

   typedef enum logic [2:0] {L_IDLE, L_SQA, L_SQB, L_MUL, L_DONE} lstate_type;

   lstate_type              st_ff;
   logic [30:0]             m_ff;
   logic [15:0]             frac_ff;
   logic [3:0]              exp_ff;
   logic [LOG_W-1:0]        loga_ff;
   logic [4:0]              cnt_ff;
   logic [LOG_W-1:0]        mag_ff;
   logic                    neg_ff;
   logic [ACC_W-1:0]        acc_ff;
   logic [MEAN_W-1:0]       den_ff;
   logic                    done_ff;
   logic signed [RAW_W-1:0] ratio_ff;

   logic [61:0]      sq;
   logic [31:0]      sqs;
   logic [30:0]      m_in;
   logic             bit_in;
   logic [LOG_W-1:0] logb;
   logic [LOG_W:0]   d;
   logic [LOG_W:0]   dneg;
   logic [ACC_W-1:0] rnd;
   logic [RAW_W-1:0] r;

   function automatic logic [3:0] msb_pos(input logic [MEAN_W-1:0] x);
      logic [3:0] p;
      p = '0;
      for (int i = 0; i < MEAN_W; i++) begin
         if (x[i]) p = 4'(i);
      end
      return p;
   endfunction

   function automatic logic [30:0] mant(input logic [MEAN_W-1:0] x);
      logic [4:0] sh;
      sh = 5'd30 - {1'b0, msb_pos(x)};
      return {15'b0, x} << sh;
   endfunction

   assign sq     = {31'b0, m_ff} * {31'b0, m_ff};
   assign sqs    = sq[61:30];
   assign bit_in = sqs[31];
   assign m_in   = bit_in ? sqs[31:1] : sqs[30:0];
   assign logb   = {exp_ff, frac_ff[14:0], bit_in};
   assign d      = {1'b0, loga_ff} - {1'b0, logb};
   assign dneg   = '0 - d;
   assign rnd    = acc_ff + (ACC_W'(1) << 29);
   assign r      = {1'b0, rnd[48:30]};

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= L_IDLE;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (st_ff)
            L_IDLE: begin
               if (start) begin
                  if (num == '0 || den == '0) begin
                     ratio_ff <= '0;
                     done_ff  <= 1'b1;
                  end else begin
                     m_ff    <= mant(num);
                     exp_ff  <= msb_pos(num);
                     frac_ff <= '0;
                     cnt_ff  <= '0;
                     den_ff  <= den;
                     st_ff   <= L_SQA;
                  end
               end
            end
            L_SQA: begin
               m_ff    <= m_in;
               frac_ff <= {frac_ff[14:0], bit_in};
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == 5'd15) begin
                  loga_ff <= logb;
                  m_ff    <= mant(den_ff);
                  exp_ff  <= msb_pos(den_ff);
                  frac_ff <= '0;
                  cnt_ff  <= '0;
                  st_ff   <= L_SQB;
               end
            end
            L_SQB: begin
               m_ff    <= m_in;
               frac_ff <= {frac_ff[14:0], bit_in};
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == 5'd15) begin
                  neg_ff <= d[LOG_W];
                  mag_ff <= d[LOG_W] ? dneg[LOG_W-1:0] : d[LOG_W-1:0];
                  acc_ff <= '0;
                  cnt_ff <= '0;
                  st_ff  <= L_MUL;
               end
            end
            L_MUL: begin
               acc_ff <= {acc_ff[ACC_W-2:0], 1'b0}
                         + (mag_ff[LOG_W-1] ? ACC_W'(LOG10_2_Q30) : '0);
               mag_ff <= {mag_ff[LOG_W-2:0], 1'b0};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 5'(LOG_W - 1)) st_ff <= L_DONE;
            end
            L_DONE: begin
               ratio_ff <= neg_ff ? -$signed(r) : $signed(r);
               done_ff  <= 1'b1;
               st_ff    <= L_IDLE;
            end
            default: st_ff <= L_IDLE;
         endcase
      end
   end

   assign done  = done_ff;
   assign ratio = ratio_ff;

endmodule

FILE: sv/absorbance_calibration_sequencer.sv
// Top level: control sequencer, round accumulation, register port and result beat.
// One beat in gives one beat out. Restart, start and reset beats and sample ticks
// that do not end a round go straight to the output register. A tick that ends a
// round runs the serial divider; one that ends a measurement adds a second division,
// and for a standard or sample a log10 ratio (two squaring passes, a scale and
// handoff), and for a sample with a valid standard one more division; the output
// register then waits out any stall on the result side. A new beat is taken once
// the previous one has reached the output register.
module absorbance_calibration_sequencer import acs_pkg::*; #(
   parameter int TICKS_PER_ROUND = TICKS_PER_ROUND_DEF,
   parameter int AVERAGE_ROUNDS  = AVERAGE_ROUNDS_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   acs_req_if.sink           req_if,
   acs_rsp_if.source         rsp_if,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((64'd1 << SAMPLE_BITS) - 64'd1);
   localparam logic [TICK_W-1:0] TICK_LIM = TICK_W'(TICKS_PER_ROUND);
   localparam logic [ROUND_W-1:0] AVG_LIM = ROUND_W'(AVERAGE_ROUNDS);

   typedef enum logic [2:0] {T_IDLE, T_RMEAN, T_FMEAN, T_LOG, T_DIV, T_OUT} tstate_type;

   tstate_type              fsm_ff;
   logic [STD_W-1:0]        std_abs_ff;
   logic [WARM_W-1:0]       warmup_ff;
   logic [SETTLE_W-1:0]     settle_ff;
   ctrl_code_type           ctrl_ff;
   phase_code_type          phase_ff;
   sub_code_type            sub_ff;
   logic [TICK_W-1:0]       tick_ff;
   logic [SUM_W-1:0]        sum_ff;
   logic [ROUND_W-1:0]      rc_ff;
   logic [TOTAL_W-1:0]      total_ff;
   logic [MEAN_W-1:0]       blank_ff;
   logic signed [RAW_W-1:0] stdlog_ff;
   logic signed [ABS_W-1:0] abs_ff;
   logic [FLAG_W-1:0]       flags_ff;
   logic [ROUND_W-1:0]      rnum_ff;
   logic                    rdone_ff;
   logic [MEAN_W-1:0]       rmean_ff;
   logic                    fdone_ff;
   logic [MEAN_W-1:0]       fmean_ff;
   logic                    neg_ff;
   logic                    div_go_ff;
   logic [PROD_W-1:0]       div_num_ff;
   logic [DEN_W-1:0]        div_den_ff;
   logic                    log_go_ff;
   logic                    rsp_valid_ff;
   logic [2:0]              o_state_ff;
   logic [2:0]              o_phase_ff;
   logic [1:0]              o_sub_ff;
   logic [ROUND_W-1:0]      o_rnum_ff;
   logic                    o_rdone_ff;
   logic [MEAN_W-1:0]       o_rmean_ff;
   logic                    o_fdone_ff;
   logic [MEAN_W-1:0]       o_fmean_ff;
   logic signed [ABS_W-1:0] o_abs_ff;
   logic [FLAG_W-1:0]       o_flags_ff;

   logic                    req_fire;
   logic                    csr_wr;
   logic [SUM_W-1:0]        sum_in;
   logic [TICK_W-1:0]       tick_in;
   logic [MEAN_W-1:0]       rmean_in;
   logic [TOTAL_W-1:0]      total_in;
   logic [ROUND_W-1:0]      rc_in;
   logic [ROUND_W-1:0]      rc_warm_in;
   logic [ROUND_W-1:0]      limit;
   logic                    div_done;
   logic [PROD_W-1:0]       div_quot;
   logic                    log_done;
   logic signed [RAW_W-1:0] log_ratio;
   logic [RAW_W-1:0]        raw_mag;
   logic [PROD_W-1:0]       prod;
   logic [ABS_W-1:0]        q_pos;
   logic [ABS_W-1:0]        q_neg;
   logic                    out_free;
   reg_index_type           reg_idx;

   assign req_fire   = req_if.valid && req_if.ready;
   assign csr_wr     = psel && penable && pwrite && pready;
   assign reg_idx    = reg_index_type'(paddr[3:2]);
   assign sum_in     = sum_ff + SUM_W'(req_if.adc_value & ADC_MASK);
   assign tick_in    = tick_ff + 1'b1;
   assign rmean_in   = div_quot[MEAN_W-1:0];
   assign total_in   = (sub_ff == SP_AVERAGE) ? total_ff + TOTAL_W'(rmean_in) : total_ff;
   assign rc_in      = rc_ff + 1'b1;
   assign rc_warm_in = (rc_ff != '1) ? rc_in : rc_ff;
   assign limit      = (sub_ff == SP_SETTLE) ? ROUND_W'(settle_ff) : AVG_LIM;
   assign raw_mag    = log_ratio[RAW_W-1] ? RAW_W'(-log_ratio) : RAW_W'(log_ratio);
   assign prod       = PROD_W'(std_abs_ff) * PROD_W'(raw_mag);
   assign q_pos      = (div_quot > PROD_W'(23'h7FFFFF)) ? 24'h7FFFFF : div_quot[ABS_W-1:0];
   assign q_neg      = (div_quot >= PROD_W'(24'h800000)) ? 24'h800000
                                                         : ABS_W'(-div_quot[ABS_W-1:0]);
   assign out_free   = !rsp_valid_ff || rsp_if.ready;

   assign req_if.ready = (fsm_ff == T_IDLE);
   assign pready       = 1'b1;

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_STD_ABS: prdata = DATA_W'(std_abs_ff);
         REG_WARMUP:  prdata = DATA_W'(warmup_ff);
         REG_SETTLE:  prdata = DATA_W'(settle_ff);
         default:     prdata = '0;
      endcase
   end

   acs_div #(.NUM_W(PROD_W), .DIV_W(DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   acs_log10 u_log (
      .clock (clock),
      .reset (reset),
      .start (log_go_ff),
      .num   (blank_ff),
      .den   (fmean_ff),
      .done  (log_done),
      .ratio (log_ratio)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= T_IDLE;
         std_abs_ff   <= STD_ABS_RST;
         warmup_ff    <= WARMUP_RST;
         settle_ff    <= SETTLE_RST;
         ctrl_ff      <= ST_WARMUP;
         phase_ff     <= PH_WARMUP;
         sub_ff       <= SP_WARMUP;
         tick_ff      <= '0;
         sum_ff       <= '0;
         rc_ff        <= '0;
         total_ff     <= '0;
         blank_ff     <= '0;
         stdlog_ff    <= '0;
         abs_ff       <= '0;
         flags_ff     <= '0;
         div_go_ff    <= 1'b0;
         log_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_go_ff <= 1'b0;
         log_go_ff <= 1'b0;
         if (rsp_valid_ff && rsp_if.ready) rsp_valid_ff <= 1'b0;

         if (csr_wr) begin
            unique case (reg_idx)
               REG_STD_ABS: if (pwdata[STD_W-1:0] != '0) std_abs_ff <= pwdata[STD_W-1:0];
               REG_WARMUP:  warmup_ff <= pwdata[WARM_W-1:0];
               REG_SETTLE:  settle_ff <= pwdata[SETTLE_W-1:0];
               default:     ;
            endcase
         end

         unique case (fsm_ff)
            T_IDLE: begin
               if (req_fire) begin
                  rnum_ff  <= '0;
                  rdone_ff <= 1'b0;
                  rmean_ff <= '0;
                  fdone_ff <= 1'b0;
                  fmean_ff <= '0;
                  fsm_ff   <= T_OUT;
                  unique case (mode_type'(req_if.mode)) inside
                     MODE_TICK: begin
                        if (ctrl_ff == ST_WARMUP || ctrl_ff == ST_MEASURING) begin
                           if (tick_in >= TICK_LIM) begin
                              tick_ff    <= '0;
                              sum_ff     <= '0;
                              div_go_ff  <= 1'b1;
                              div_num_ff <= PROD_W'({sum_in, 4'b0});
                              div_den_ff <= DEN_W'(TICK_LIM);
                              fsm_ff     <= T_RMEAN;
                           end else begin
                              tick_ff <= tick_in;
                              sum_ff  <= sum_in;
                           end
                        end
                     end
                     MODE_START: begin
                        if (ctrl_ff == ST_AW_BLANK || ctrl_ff == ST_AW_STD
                            || ctrl_ff == ST_AW_SAMPLE) begin
                           ctrl_ff  <= ST_MEASURING;
                           sub_ff   <= SP_SETTLE;
                           rc_ff    <= '0;
                           tick_ff  <= '0;
                           sum_ff   <= '0;
                           total_ff <= '0;
                           if (ctrl_ff == ST_AW_BLANK) begin
                              phase_ff  <= PH_BLANK;
                              flags_ff  <= '0;
                              stdlog_ff <= '0;
                           end else if (ctrl_ff == ST_AW_STD) begin
                              phase_ff <= PH_STD;
                              flags_ff <= flags_ff & 3'b001;
                           end else begin
                              phase_ff <= PH_SAMPLE;
                              flags_ff <= flags_ff & 3'b011;
                           end
                        end
                     end
                     MODE_RESTART, MODE_RESET: begin
                        if ((req_if.mode == MODE_RESTART && ctrl_ff != ST_WARMUP)
                            || (req_if.mode == MODE_RESET && ctrl_ff != ST_MEASURING)) begin
                           flags_ff  <= '0;
                           blank_ff  <= '0;
                           stdlog_ff <= '0;
                           abs_ff    <= '0;
                           phase_ff  <= PH_NONE;
                           sub_ff    <= SP_NONE;
                           ctrl_ff   <= ST_AW_BLANK;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            T_RMEAN: begin
               if (div_done) begin
                  rmean_ff <= rmean_in;
                  rdone_ff <= 1'b1;
                  fsm_ff   <= T_OUT;
                  if (ctrl_ff == ST_WARMUP) begin
                     rc_ff   <= rc_warm_in;
                     rnum_ff <= rc_warm_in;
                     if (rc_warm_in >= warmup_ff) begin
                        ctrl_ff  <= ST_AW_BLANK;
                        phase_ff <= PH_NONE;
                        sub_ff   <= SP_NONE;
                     end
                  end else begin
                     rnum_ff  <= rc_in;
                     rc_ff    <= rc_in;
                     total_ff <= total_in;
                     if (rc_in >= limit) begin
                        if (sub_ff == SP_SETTLE) begin
                           sub_ff   <= SP_AVERAGE;
                           rc_ff    <= '0;
                           tick_ff  <= '0;
                           sum_ff   <= '0;
                           total_ff <= '0;
                        end else begin
                           div_go_ff  <= 1'b1;
                           div_num_ff <= PROD_W'(total_in);
                           div_den_ff <= DEN_W'(AVG_LIM);
                           fsm_ff     <= T_FMEAN;
                        end
                     end
                  end
               end
            end
            T_FMEAN: begin
               if (div_done) begin
                  fmean_ff <= div_quot[MEAN_W-1:0];
                  fdone_ff <= 1'b1;
                  if (phase_ff == PH_STD || phase_ff == PH_SAMPLE) begin
                     log_go_ff <= 1'b1;
                     fsm_ff    <= T_LOG;
                  end else begin
                     if (phase_ff == PH_BLANK) begin
                        blank_ff <= div_quot[MEAN_W-1:0];
                        flags_ff <= flags_ff | 3'b001;
                        ctrl_ff  <= ST_AW_STD;
                     end else begin
                        ctrl_ff <= ST_AW_BLANK;
                     end
                     phase_ff <= PH_NONE;
                     sub_ff   <= SP_NONE;
                     fsm_ff   <= T_OUT;
                  end
               end
            end
            T_LOG: begin
               if (log_done) begin
                  fsm_ff <= T_OUT;
                  if (phase_ff == PH_STD) begin
                     if (log_ratio > 0) begin
                        stdlog_ff <= log_ratio;
                        flags_ff  <= flags_ff | 3'b010;
                     end else begin
                        stdlog_ff <= '0;
                        flags_ff  <= flags_ff & 3'b101;
                     end
                     ctrl_ff  <= ST_AW_SAMPLE;
                     phase_ff <= PH_NONE;
                     sub_ff   <= SP_NONE;
                  end else if (flags_ff[1] && stdlog_ff > 0) begin
                     neg_ff     <= log_ratio[RAW_W-1];
                     div_go_ff  <= 1'b1;
                     div_num_ff <= prod;
                     div_den_ff <= DEN_W'(stdlog_ff);
                     fsm_ff     <= T_DIV;
                  end else begin
                     abs_ff   <= ABS_W'(log_ratio);
                     flags_ff <= flags_ff | 3'b100;
                     ctrl_ff  <= ST_AW_SAMPLE;
                     phase_ff <= PH_NONE;
                     sub_ff   <= SP_NONE;
                  end
               end
            end
            T_DIV: begin
               if (div_done) begin
                  abs_ff   <= neg_ff ? q_neg : q_pos;
                  flags_ff <= flags_ff | 3'b100;
                  ctrl_ff  <= ST_AW_SAMPLE;
                  phase_ff <= PH_NONE;
                  sub_ff   <= SP_NONE;
                  fsm_ff   <= T_OUT;
               end
            end
            T_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  o_state_ff   <= ctrl_ff;
                  o_phase_ff   <= phase_ff;
                  o_sub_ff     <= sub_ff;
                  o_rnum_ff    <= rnum_ff;
                  o_rdone_ff   <= rdone_ff;
                  o_rmean_ff   <= rmean_ff;
                  o_fdone_ff   <= fdone_ff;
                  o_fmean_ff   <= fmean_ff;
                  o_abs_ff     <= abs_ff;
                  o_flags_ff   <= flags_ff;
                  fsm_ff       <= T_IDLE;
               end
            end
            default: fsm_ff <= T_IDLE;
         endcase
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.state_code     = o_state_ff;
   assign rsp_if.phase_code     = o_phase_ff;
   assign rsp_if.subphase_code  = o_sub_ff;
   assign rsp_if.round_number   = o_rnum_ff;
   assign rsp_if.round_done     = o_rdone_ff;
   assign rsp_if.round_mean_q4  = o_rmean_ff;
   assign rsp_if.final_done     = o_fdone_ff;
   assign rsp_if.final_mean_q4  = o_fmean_ff;
   assign rsp_if.absorbance_q16 = o_abs_ff;
   assign rsp_if.calib_flags    = o_flags_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> fsm_ff != T_IDLE)
      else $error("sequencer idle right after accepting a beat");

   a_flags_need_blank: assert property (@(posedge clock) disable iff (reset)
      (flags_ff[1] || flags_ff[2]) |-> flags_ff[0])
      else $error("standard or sample flag without blank flag");

   a_std_flag_log: assert property (@(posedge clock) disable iff (reset)
      flags_ff[1] |-> stdlog_ff > 0)
      else $error("standard flag set with nonpositive log ratio");

   a_measure_phase: assert property (@(posedge clock) disable iff (reset)
      ctrl_ff == ST_MEASURING |->
         (phase_ff == PH_BLANK || phase_ff == PH_STD || phase_ff == PH_SAMPLE))
      else $error("measuring without a measurement phase");

endmodule
